### src/fbnp_pkg.sv
// Shared constants and types for the file block to node path locator.
// Used by file_block_to_node_path and fbnp_cdiv; depends on nothing else.
package fbnp_pkg;

  // Index tree geometry
  localparam int unsigned ADDRS_IN_INODE     = 923;
  localparam int unsigned ADDRS_IN_NODE      = 1018;
  localparam int unsigned POINTERS_IN_NODE   = 1018;
  localparam int unsigned FIRST_POINTER_SLOT = 924;

  // Fixed result field widths
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned NODE1_W = 11;
  localparam int unsigned NODE_W  = 20;

  // Fixed-point shift of the reciprocal used by the constant dividers
  localparam int unsigned RECIP_SHIFT = 32;

  // Which part of the tree a block falls in
  typedef enum logic [2:0] {
    RGN_INODE,
    RGN_DIR0,
    RGN_DIR1,
    RGN_IND0,
    RGN_IND1,
    RGN_DIND,
    RGN_BEYOND
  } region_t;

  // Per-item data carried alongside the divider pipelines
  typedef struct packed {
    region_t             region;
    logic [SLOT_W-1:0]   low_slot;
    logic [NODE_W-1:0]   quo;
    logic [SLOT_W-1:0]   rem;
  } side_t;

endpackage

### src/fbnp_cdiv.sv
// Three-stage pipelined divider by a constant: reciprocal multiply,
// back-multiply and subtract, then a single correction step.
// Depends on fbnp_pkg.
module fbnp_cdiv #(
  parameter int unsigned DIVIDEND_W = 31,
  parameter int unsigned QUO_W      = 20,
  parameter int unsigned REM_W      = 10,
  parameter int unsigned DIVISOR    = 1018
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic [QUO_W-1:0]      quo,
  output logic [REM_W-1:0]      rem
);
  import fbnp_pkg::*;

  localparam int unsigned PW = DIVIDEND_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam logic [REM_W:0] DIV_R = (REM_W + 1)'(DIVISOR);

  logic [PW-1:0]         prod;
  logic [QUO_W-1:0]      qe_a_nxt, qe_a_r, qe_b_r, quo_r;
  logic [DIVIDEND_W-1:0] d_a_r;
  logic [DIVIDEND_W-1:0] back, diff;
  logic [REM_W:0]        rem0_r;
  logic [REM_W-1:0]      rem_r;

  // estimate is exact or one low
  assign prod     = PW'(dividend) * PW'(RECIP);
  assign qe_a_nxt = prod[RECIP_SHIFT +: QUO_W];

  assign back = DIVIDEND_W'(qe_a_r) * DIVIDEND_W'(DIVISOR);
  assign diff = d_a_r - back;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      qe_a_r <= qe_a_nxt;
      d_a_r  <= dividend;
    end
    if (en[1]) begin
      qe_b_r <= qe_a_r;
      rem0_r <= diff[REM_W:0];
    end
    if (en[2]) begin
      if (rem0_r >= DIV_R) begin
        quo_r <= qe_b_r + QUO_W'(1);
        rem_r <= REM_W'(rem0_r - DIV_R);
      end else begin
        quo_r <= qe_b_r;
        rem_r <= rem0_r[REM_W-1:0];
      end
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

### src/file_block_to_node_path.sv
// Top level of the file block to node path locator.
// Depends on fbnp_pkg and fbnp_cdiv.
//
// Maps a file-relative block number to its path through the inode, direct,
// indirect and double-indirect node blocks: depth, validity, the slot at each
// level and the logical node number of each node block on the path. Unused
// levels read as zero, and a block beyond the tree gives path_valid low with
// every other field zero. The block takes one item per clock while out_stall
// is low and passes each item through a 9-register pipeline: input register,
// region classify, then two constant dividers of three stages each (by the
// node address count, then by the node pointer count, each a reciprocal
// multiply, a back-multiply and a correction), then the result register.
// Every stage has its own valid bit and moves whenever it is empty or the
// stage after it is moving, so bubbles close up and new items are taken
// while a result waits on out_stall, until the pipeline is full.
module file_block_to_node_path (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_block_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_path_valid,
  output logic [1:0]  out_depth,
  output logic [9:0]  out_slot_level0,
  output logic [9:0]  out_slot_level1,
  output logic [9:0]  out_slot_level2,
  output logic [9:0]  out_slot_level3,
  output logic [10:0] out_node_number_level1,
  output logic [19:0] out_node_number_level2,
  output logic [19:0] out_node_number_level3
);
  import fbnp_pkg::*;

  localparam int unsigned NSTG = 9;
  localparam int unsigned LAST = NSTG - 1;

  // region boundaries in block number space
  localparam logic [32:0] IND_SPAN  = 33'(ADDRS_IN_NODE) * 33'(POINTERS_IN_NODE);
  localparam logic [32:0] DIND_SPAN = IND_SPAN * 33'(POINTERS_IN_NODE);
  localparam logic [32:0] LIM_DIR0  = 33'(ADDRS_IN_INODE);
  localparam logic [32:0] LIM_DIR1  = LIM_DIR0 + 33'(ADDRS_IN_NODE);
  localparam logic [32:0] LIM_IND0  = LIM_DIR1 + 33'(ADDRS_IN_NODE);
  localparam logic [32:0] LIM_IND1  = LIM_IND0 + IND_SPAN;
  localparam logic [32:0] LIM_DIND  = LIM_IND1 + IND_SPAN;
  localparam logic [32:0] LIM_END   = LIM_DIND + DIND_SPAN;

  // fixed slots and node numbers
  localparam logic [SLOT_W-1:0]  S0_DIR0 = SLOT_W'(FIRST_POINTER_SLOT);
  localparam logic [SLOT_W-1:0]  S0_DIR1 = SLOT_W'(FIRST_POINTER_SLOT + 1);
  localparam logic [SLOT_W-1:0]  S0_IND0 = SLOT_W'(FIRST_POINTER_SLOT + 2);
  localparam logic [SLOT_W-1:0]  S0_IND1 = SLOT_W'(FIRST_POINTER_SLOT + 3);
  localparam logic [SLOT_W-1:0]  S0_DIND = SLOT_W'(FIRST_POINTER_SLOT + 4);
  localparam logic [NODE1_W-1:0] N1_DIR0 = NODE1_W'(1);
  localparam logic [NODE1_W-1:0] N1_DIR1 = NODE1_W'(2);
  localparam logic [NODE1_W-1:0] N1_IND0 = NODE1_W'(3);
  localparam logic [NODE1_W-1:0] N1_IND1 = NODE1_W'(4 + POINTERS_IN_NODE);
  localparam logic [NODE1_W-1:0] N1_DIND = NODE1_W'(5 + 2 * POINTERS_IN_NODE);
  // node number sums are formed one bit wider and then cut to field width
  localparam int unsigned        NW      = NODE_W + 1;
  localparam logic [NW-1:0]      N2_IND0 = NW'(4);
  localparam logic [NW-1:0]      N2_IND1 = NW'(5 + POINTERS_IN_NODE);
  localparam logic [NW-1:0]      N2_DIND = NW'(6 + 2 * POINTERS_IN_NODE);

  // ---------------- handshake: per-stage valid and move enables
  logic [LAST:0] v_r, v_nxt, en;

  always_comb begin
    en[LAST] = !v_r[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[LAST];

  // ---------------- stage 0: input register
  logic [31:0] block_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      block_r <= in_block_number;
    end
  end

  // ---------------- stage 1: region classify and offset within region
  logic [32:0] b33, base, diff;
  region_t     region_nxt;
  side_t       side1_nxt;
  logic [30:0] r1_r;
  side_t       side_r [1:7];

  assign b33 = {1'b0, block_r};

  always_comb begin
    priority if (b33 < LIM_DIR0) begin
      region_nxt = RGN_INODE;
      base       = '0;
    end else if (b33 < LIM_DIR1) begin
      region_nxt = RGN_DIR0;
      base       = LIM_DIR0;
    end else if (b33 < LIM_IND0) begin
      region_nxt = RGN_DIR1;
      base       = LIM_DIR1;
    end else if (b33 < LIM_IND1) begin
      region_nxt = RGN_IND0;
      base       = LIM_IND0;
    end else if (b33 < LIM_DIND) begin
      region_nxt = RGN_IND1;
      base       = LIM_IND1;
    end else if (b33 < LIM_END) begin
      region_nxt = RGN_DIND;
      base       = LIM_DIND;
    end else begin
      region_nxt = RGN_BEYOND;
      base       = '0;
    end
    diff = b33 - base;
  end

  always_comb begin
    side1_nxt          = '0;
    side1_nxt.region   = region_nxt;
    side1_nxt.low_slot = diff[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_r <= diff[30:0];
    end
  end

  // ---------------- stages 2-4: offset / addresses per node
  logic [NODE_W-1:0] qa;
  logic [SLOT_W-1:0] rema;

  fbnp_cdiv #(
    .DIVIDEND_W (31),
    .QUO_W      (NODE_W),
    .REM_W      (SLOT_W),
    .DIVISOR    (ADDRS_IN_NODE)
  ) u_div_addr (
    .clk      (clk),
    .en       (en[4:2]),
    .dividend (r1_r),
    .quo      (qa),
    .rem      (rema)
  );

  // ---------------- stages 5-7: quotient / pointers per node
  logic [SLOT_W-1:0] qb, remb;

  fbnp_cdiv #(
    .DIVIDEND_W (NODE_W),
    .QUO_W      (SLOT_W),
    .REM_W      (SLOT_W),
    .DIVISOR    (POINTERS_IN_NODE)
  ) u_div_ptr (
    .clk      (clk),
    .en       (en[7:5]),
    .dividend (qa),
    .quo      (qb),
    .rem      (remb)
  );

  // side data tracks the divider stages; first quotient joins at stage 5
  side_t side5_nxt;

  always_comb begin
    side5_nxt     = side_r[4];
    side5_nxt.quo = qa;
    side5_nxt.rem = rema;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1] <= side1_nxt;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        side_r[k] <= (k == 5) ? side5_nxt : side_r[k-1];
      end
    end
  end

  // ---------------- stage 8: assemble the path
  side_t               sd;
  logic [NW-1:0]       n2_dind, n3_dind;
  logic                pv_nxt;
  logic [1:0]          depth_nxt;
  logic [SLOT_W-1:0]   s0_nxt, s1_nxt, s2_nxt, s3_nxt;
  logic [NODE1_W-1:0]  n1_nxt;
  logic [NODE_W-1:0]   n2_nxt, n3_nxt;

  assign sd = side_r[7];

  // quo = s1 * P + s2, so s1 * (P + 1) = quo - s2 + s1
  assign n2_dind = N2_DIND + NW'(sd.quo) - NW'(remb) + NW'(qb);
  assign n3_dind = n2_dind + NW'(1) + NW'(remb);

  always_comb begin
    pv_nxt    = 1'b1;
    depth_nxt = 2'd0;
    s0_nxt    = '0;
    s1_nxt    = '0;
    s2_nxt    = '0;
    s3_nxt    = '0;
    n1_nxt    = '0;
    n2_nxt    = '0;
    n3_nxt    = '0;
    unique case (sd.region)
      RGN_INODE: begin
        s0_nxt = sd.low_slot;
      end
      RGN_DIR0: begin
        depth_nxt = 2'd1;
        s0_nxt    = S0_DIR0;
        n1_nxt    = N1_DIR0;
        s1_nxt    = sd.low_slot;
      end
      RGN_DIR1: begin
        depth_nxt = 2'd1;
        s0_nxt    = S0_DIR1;
        n1_nxt    = N1_DIR1;
        s1_nxt    = sd.low_slot;
      end
      RGN_IND0: begin
        depth_nxt = 2'd2;
        s0_nxt    = S0_IND0;
        n1_nxt    = N1_IND0;
        s1_nxt    = sd.quo[SLOT_W-1:0];
        s2_nxt    = sd.rem;
        n2_nxt    = NODE_W'(N2_IND0 + NW'(sd.quo));
      end
      RGN_IND1: begin
        depth_nxt = 2'd2;
        s0_nxt    = S0_IND1;
        n1_nxt    = N1_IND1;
        s1_nxt    = sd.quo[SLOT_W-1:0];
        s2_nxt    = sd.rem;
        n2_nxt    = NODE_W'(N2_IND1 + NW'(sd.quo));
      end
      RGN_DIND: begin
        depth_nxt = 2'd3;
        s0_nxt    = S0_DIND;
        n1_nxt    = N1_DIND;
        s1_nxt    = qb;
        s2_nxt    = remb;
        s3_nxt    = sd.rem;
        n2_nxt    = n2_dind[NODE_W-1:0];
        n3_nxt    = n3_dind[NODE_W-1:0];
      end
      default: begin
        // beyond the tree: everything reads zero
        pv_nxt = 1'b0;
      end
    endcase
  end

  logic               pv_r;
  logic [1:0]         depth_r;
  logic [SLOT_W-1:0]  s0_r, s1_r, s2_r, s3_r;
  logic [NODE1_W-1:0] n1_r;
  logic [NODE_W-1:0]  n2_r, n3_r;

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      pv_r    <= pv_nxt;
      depth_r <= depth_nxt;
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      n1_r    <= n1_nxt;
      n2_r    <= n2_nxt;
      n3_r    <= n3_nxt;
    end
  end

  assign out_path_valid         = pv_r;
  assign out_depth              = depth_r;
  assign out_slot_level0        = s0_r;
  assign out_slot_level1        = s1_r;
  assign out_slot_level2        = s2_r;
  assign out_slot_level3        = s3_r;
  assign out_node_number_level1 = n1_r;
  assign out_node_number_level2 = n2_r;
  assign out_node_number_level3 = n3_r;

endmodule
